// ===== rtl/sftl_pkg.sv =====
`default_nettype none
package sftl_pkg;

	localparam int INDEX_BITS  = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	// topology codes carried on func
	localparam logic [1:0] TOPO_LIST  = 2'd0;
	localparam logic [1:0] TOPO_STRIP = 2'd1;
	localparam logic [1:0] TOPO_FAN   = 2'd2;

	// strip and fan indices that pass through before triangles are built
	localparam logic [1:0] PASS_COUNT = 2'd3;

	typedef logic [INDEX_BITS-1:0] index_t;

	// one queued job: up to three offset indices, emitted idx0 first
	typedef struct packed {
		logic [1:0] count;
		index_t     idx0;
		index_t     idx1;
		index_t     idx2;
	} sftl_entry_t;

	typedef struct packed {
		logic        valid;
		sftl_entry_t entry;
	} sftl_slot_t;

endpackage
`default_nettype wire

// ===== rtl/sftl_front.sv =====
`default_nettype none
module sftl_front
	import sftl_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] func,
	input  wire logic       start_of_fragment,
	input  wire index_t     base_vertex,
	input  wire index_t     vertex_index,
	input  wire logic       queue_full,
	output sftl_slot_t      push
);

	index_t     fan_center_q;
	index_t     prior_index_q;
	index_t     older_index_q;
	index_t     held_offset_q;
	logic [1:0] position_count_q;
	logic       odd_position_q;

	index_t      offset;
	index_t      center;
	logic [1:0]  pos;
	logic        odd;
	index_t      raw0;
	index_t      raw1;
	index_t      raw2;
	logic [1:0]  count;
	logic        accept;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		// a fragment start restarts position and parity and takes the new base
		offset = start_of_fragment ? base_vertex : held_offset_q;
		pos    = start_of_fragment ? 2'd0 : position_count_q;
		odd    = start_of_fragment ? 1'b0 : odd_position_q;
		center = (pos == 2'd0) ? vertex_index : fan_center_q;
		raw0   = vertex_index;
		raw1   = prior_index_q;
		raw2   = older_index_q;
		count  = 2'd0;
		if (func == TOPO_LIST || pos < PASS_COUNT) begin
			if (func == TOPO_LIST || func == TOPO_STRIP || func == TOPO_FAN)
				count = 2'd1;
		end else begin
			case (func)
				TOPO_STRIP: begin
					count = 2'd3;
					if (odd) begin
						raw0 = vertex_index;
						raw2 = older_index_q;
					end else begin
						raw0 = older_index_q;
						raw2 = vertex_index;
					end
				end
				TOPO_FAN: begin
					count = 2'd3;
					raw0  = center;
					raw2  = vertex_index;
				end
				default: count = 2'd0;
			endcase
		end
		push.valid       = accept && (count != 2'd0);
		push.entry.count = count;
		push.entry.idx0  = raw0 + offset;
		push.entry.idx1  = raw1 + offset;
		push.entry.idx2  = raw2 + offset;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fan_center_q     <= '0;
			prior_index_q    <= '0;
			older_index_q    <= '0;
			held_offset_q    <= '0;
			position_count_q <= 2'd0;
			odd_position_q   <= 1'b0;
		end else if (accept) begin
			held_offset_q  <= offset;
			fan_center_q   <= center;
			older_index_q  <= prior_index_q;
			prior_index_q  <= vertex_index;
			odd_position_q <= ~odd;
			if (pos < PASS_COUNT)
				position_count_q <= pos + 2'd1;
			else
				position_count_q <= pos;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sftl_queue.sv =====
`default_nettype none
module sftl_queue
	import sftl_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire sftl_slot_t push,
	output logic            full,
	input  wire logic       pop_ready,
	output sftl_slot_t      head
);

	sftl_entry_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]   wr_ptr_q;
	logic [QPTR_BITS-1:0]   rd_ptr_q;
	logic [QCNT_BITS-1:0]   count_q;
	logic                   do_push;
	logic                   do_pop;

	assign full       = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.entry = mem_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop_ready && head.valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push.entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= QPTR_BITS'((32'(wr_ptr_q) + 1) % QUEUE_DEPTH);
			if (do_pop)
				rd_ptr_q <= QPTR_BITS'((32'(rd_ptr_q) + 1) % QUEUE_DEPTH);
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QCNT_BITS'(1);
				2'b01:   count_q <= count_q - QCNT_BITS'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sftl_back.sv =====
`default_nettype none
module sftl_back
	import sftl_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire sftl_slot_t head,
	output logic            pop_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	output index_t          out_index,
	output logic            last
);

	logic        work_valid_q;
	sftl_entry_t work_q;
	logic [1:0]  pos_q;
	logic        out_valid_q;
	index_t      out_index_q;
	logic        last_q;

	logic        work_take;
	logic        work_last;
	index_t      sel_index;

	assign work_take = work_valid_q && (!out_valid_q || out_ready);
	assign work_last = (pos_q == work_q.count - 2'd1);
	assign pop_ready = !work_valid_q || (work_take && work_last);

	always_comb begin
		case (pos_q)
			2'd0:    sel_index = work_q.idx0;
			2'd1:    sel_index = work_q.idx1;
			default: sel_index = work_q.idx2;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_valid_q <= 1'b0;
			pos_q        <= 2'd0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop_ready) begin
				work_valid_q <= head.valid;
				pos_q        <= 2'd0;
			end else if (work_take) begin
				pos_q <= pos_q + 2'd1;
			end
			if (work_take)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ready && head.valid)
			work_q <= head.entry;
		if (work_take) begin
			out_index_q <= sel_index;
			last_q      <= work_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign last      = last_q;

endmodule
`default_nettype wire

// ===== rtl/strip_fan_to_triangle_list_core.sv =====
// channel  handshake             payload
// in       in_valid / in_ready   func, start_of_fragment, base_vertex, vertex_index
// out      out_valid / out_ready out_index, last
//
// one result leaves per cycle while out_ready holds; an item causes one result
// for a pass-through index and three for a strip or fan triangle
// the front takes an item every cycle while the four-entry job queue has room
// a result goes via the job queue and the work register into the output register
// reset clears the fragment state to zero and empties queue and output register
// a stalled output holds the queue; the input side stalls only on a full queue
`default_nettype none
module strip_fan_to_triangle_list_core
	import sftl_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] func,
	input  wire logic       start_of_fragment,
	input  wire index_t     base_vertex,
	input  wire index_t     vertex_index,
	output logic            out_valid,
	input  wire logic       out_ready,
	output index_t          out_index,
	output logic            last
);

	sftl_slot_t push;
	sftl_slot_t head;
	logic       queue_full;
	logic       pop_ready;

	sftl_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.func              (func),
		.start_of_fragment (start_of_fragment),
		.base_vertex       (base_vertex),
		.vertex_index      (vertex_index),
		.queue_full        (queue_full),
		.push              (push)
	);

	sftl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (queue_full),
		.pop_ready (pop_ready),
		.head      (head)
	);

	sftl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop_ready (pop_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_index (out_index),
		.last      (last)
	);

	// a job never arrives at a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !queue_full)
		else $error("job pushed into full queue");

	// every list index transfer becomes a single-result job
	a_list_push: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && func == TOPO_LIST) |->
		(push.valid && push.entry.count == 2'd1))
		else $error("list index did not queue one result");

	// queued jobs always carry at least one result
	a_head_count: assert property (@(posedge clk) disable iff (!arst_n)
		head.valid |-> (head.entry.count == 2'd1 || head.entry.count == 2'd3))
		else $error("queue head holds a bad result count");

endmodule
`default_nettype wire

// ===== tb/strip_fan_to_triangle_list_core_test.sv =====
`timescale 1ns / 100ps
module strip_fan_to_triangle_list_core_test;
	import sftl_pkg::*;

	localparam logic [1:0] TOPO_UNKNOWN = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct {
		index_t idx;
		logic   last;
	} list_index_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] func;
	logic       start_of_fragment;
	index_t     base_vertex;
	index_t     vertex_index;
	logic       out_valid;
	logic       out_ready;
	index_t     out_index;
	logic       last;

	// fragment state mirrored from the block
	index_t     fan_center;
	index_t     prior_index;
	index_t     older_index;
	index_t     held_offset;
	logic [1:0] position_count;
	logic       odd_position;

	list_index_t pending_indices[$];
	list_index_t want;
	int          errors;
	int          cycle_count;
	int          send_idle_pct;
	int          recv_stall_pct;

	strip_fan_to_triangle_list_core u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.func              (func),
		.start_of_fragment (start_of_fragment),
		.base_vertex       (base_vertex),
		.vertex_index      (vertex_index),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.out_index         (out_index),
		.last              (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic assemble_triangles(input logic [1:0] f, input logic sof, input index_t base,
			input index_t cur);
		index_t      picks[3];
		index_t      sum;
		list_index_t item;
		int          n;
		n = 0;
		if (sof) begin
			held_offset    = base;
			position_count = '0;
			odd_position   = 1'b0;
		end
		if (position_count == 0)
			fan_center = cur;
		if (f == TOPO_LIST || position_count < PASS_COUNT) begin
			if (f != TOPO_UNKNOWN) begin
				picks[0] = cur;
				n = 1;
			end
		end else if (f == TOPO_STRIP) begin
			// odd positions flip the winding
			if (odd_position) begin
				picks[0] = cur;
				picks[1] = prior_index;
				picks[2] = older_index;
			end else begin
				picks[0] = older_index;
				picks[1] = prior_index;
				picks[2] = cur;
			end
			n = 3;
		end else if (f == TOPO_FAN) begin
			picks[0] = fan_center;
			picks[1] = prior_index;
			picks[2] = cur;
			n = 3;
		end
		for (int k = 0; k < n; k++) begin
			sum = picks[k] + held_offset;
			item.idx  = sum;
			item.last = (k == n - 1);
			pending_indices.push_back(item);
		end
		older_index = prior_index;
		prior_index = cur;
		if (position_count < PASS_COUNT)
			position_count = position_count + 2'd1;
		odd_position = ~odd_position;
	endtask

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			assemble_triangles(func, start_of_fragment, base_vertex, vertex_index);
		if (arst_n && out_valid && out_ready) begin
			if (pending_indices.size() == 0) begin
				$display("%0t: unexpected result out_index=%h last=%b", $time, out_index, last);
				errors++;
			end else begin
				want = pending_indices.pop_front();
				if (out_index !== want.idx) begin
					$display("%0t: out_index expected %h actual %h", $time, want.idx, out_index);
					errors++;
				end
				if (last !== want.last) begin
					$display("%0t: last expected %b actual %b", $time, want.last, last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("strip_fan_to_triangle_list_core_test: done, errors");
			$finish;
		end
	end

	always @(negedge clk)
		out_ready = ($urandom_range(99) >= recv_stall_pct);

	function automatic index_t pick_index();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return index_t'($urandom);
		endcase
	endfunction

	// one input transfer; returns at the falling edge after acceptance
	task automatic send_index(input logic [1:0] f, input logic sof, input index_t base,
			input index_t idx);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid          = 1'b1;
		func              = f;
		start_of_fragment = sof;
		base_vertex       = base;
		vertex_index      = idx;
		// ready is stable between edges, so check it at the falling edge
		while (!in_ready)
			@(negedge clk);
		@(negedge clk);
	endtask

	task automatic random_fragments(input int item_total);
		int         sent;
		int         span;
		logic [1:0] topo;
		logic [1:0] f;
		logic       sof;
		index_t     base;
		sent = 0;
		while (sent < item_total) begin
			topo = 2'($urandom_range(2));
			span = $urandom_range(1, 8);
			base = pick_index();
			for (int k = 0; k < span && sent < item_total; k++) begin
				f   = topo;
				sof = (k == 0);
				// occasional noise: any topology, a stray start or a missed one
				case ($urandom_range(15))
					0: f = 2'($urandom_range(3));
					1: sof = ~sof;
					default: ;
				endcase
				send_index(f, sof, sof ? base : pick_index(), pick_index());
				sent++;
			end
		end
	endtask

	task automatic test_list_passthrough();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		// no fragment started yet, so no offset
		send_index(TOPO_LIST, 1'b0, 16'h1234, 16'hffff);
		send_index(TOPO_LIST, 1'b1, 16'hffff, 16'hffff);
		// base ignored without a start
		send_index(TOPO_LIST, 1'b0, 16'h0000, 16'h0001);
		send_index(TOPO_LIST, 1'b1, 16'h0000, 16'h0000);
	endtask

	task automatic test_strip_winding();
		send_index(TOPO_STRIP, 1'b1, 16'h0010, 16'h000a);
		send_index(TOPO_STRIP, 1'b0, 16'hffff, 16'h000b);
		send_index(TOPO_STRIP, 1'b0, 16'h0000, 16'h000c);
		send_index(TOPO_STRIP, 1'b0, 16'h0000, 16'h000d);
		send_index(TOPO_STRIP, 1'b0, 16'h0000, 16'h000e);
		send_index(TOPO_STRIP, 1'b0, 16'h0000, 16'hffff);
	endtask

	task automatic test_fan_triangles();
		send_index(TOPO_FAN, 1'b1, 16'h8000, 16'h7fff);
		send_index(TOPO_FAN, 1'b0, 16'h0000, 16'h8000);
		send_index(TOPO_FAN, 1'b0, 16'h0000, 16'h0001);
		send_index(TOPO_FAN, 1'b0, 16'h0000, 16'hfffe);
		send_index(TOPO_FAN, 1'b0, 16'h5555, 16'haaaa);
	endtask

	task automatic test_odd_cases();
		send_index(TOPO_STRIP, 1'b1, 16'h0001, 16'h0100);
		send_index(TOPO_STRIP, 1'b0, 16'h0000, 16'h0200);
		send_index(TOPO_STRIP, 1'b0, 16'h0000, 16'h0300);
		// unknown topology emits nothing but still shifts the index history and parity
		send_index(TOPO_UNKNOWN, 1'b0, 16'h0000, 16'h0400);
		// topology switches in the middle of a fragment
		send_index(TOPO_FAN, 1'b0, 16'h0000, 16'h0500);
		send_index(TOPO_LIST, 1'b0, 16'h0000, 16'h0600);
		send_index(TOPO_STRIP, 1'b0, 16'h0000, 16'h0700);
		send_index(TOPO_UNKNOWN, 1'b1, 16'hfff0, 16'h0020);
		send_index(TOPO_FAN, 1'b0, 16'h0000, 16'h0021);
	endtask

	task automatic test_no_idling();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		random_fragments(28);
	endtask

	task automatic test_sender_idle();
		send_idle_pct  = 80;
		recv_stall_pct = 0;
		random_fragments(25);
	endtask

	task automatic test_receiver_stall();
		send_idle_pct  = 0;
		recv_stall_pct = 80;
		random_fragments(28);
	endtask

	task automatic test_both_idle();
		send_idle_pct  = 27;
		recv_stall_pct = 27;
		random_fragments(25);
	endtask

	initial begin
		clk               = 1'b0;
		arst_n            = 1'b0;
		in_valid          = 1'b0;
		func              = TOPO_LIST;
		start_of_fragment = 1'b0;
		base_vertex       = '0;
		vertex_index      = '0;
		out_ready         = 1'b0;
		errors            = 0;
		cycle_count       = 0;
		send_idle_pct     = 0;
		recv_stall_pct    = 0;
		fan_center        = '0;
		prior_index       = '0;
		older_index       = '0;
		held_offset       = '0;
		position_count    = '0;
		odd_position      = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_list_passthrough();
		test_strip_winding();
		test_fan_triangles();
		test_odd_cases();
		test_no_idling();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();

		in_valid = 1'b0;
		while (pending_indices.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("strip_fan_to_triangle_list_core_test: done, clean");
		else
			$display("strip_fan_to_triangle_list_core_test: done, errors");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/sftl_pkg.sv
rtl/sftl_front.sv
rtl/sftl_queue.sv
rtl/sftl_back.sv
rtl/strip_fan_to_triangle_list_core.sv
tb/strip_fan_to_triangle_list_core_test.sv
